// ===== rtl/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
package u2u_pkg;

  localparam int unsigned ACC_W  = 21;
  localparam int unsigned LEFT_W = 2;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned ST_W   = 3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ASTRAL   = 3'd1;
  localparam logic [ST_W-1:0] ST_TOO_BIG  = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_LEAD = 3'd3;
  localparam logic [ST_W-1:0] ST_TRUNC    = 3'd4;

  localparam logic [ACC_W-1:0] BMP_TOP     = 21'h00FFFF;
  localparam logic [ACC_W-1:0] UNICODE_TOP = 21'h10FFFF;

  // One input request as held in the input register.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_of_name;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic [ST_W-1:0]   status;
    logic              end_of_name;
  } result_t;

  // Decoder state visible to the top level for checking.
  typedef struct packed {
    logic [LEFT_W-1:0] bytes_left;
    logic [LEN_W-1:0]  seq_length;
    logic              name_aborted;
  } core_state_t;

endpackage

// ===== rtl/u2u_in_reg.sv =====
// Input register stage: holds one byte request until the decoder consumes it.
module u2u_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  u2u_pkg::in_item_t in_item,
  input  logic              step_ok,
  output logic              s1_valid,
  output u2u_pkg::in_item_t s1_item
);
  import u2u_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     take;

  // Advance the held request whenever the decoder can step.
  assign in_stall = s1_valid_r & ~step_ok;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (step_ok) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ===== rtl/u2u_core.sv =====
// Decode core: sequence state registers and the per-byte decode logic.
module u2u_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  u2u_pkg::in_item_t   item,
  output logic                res_valid,
  output u2u_pkg::result_t    res,
  output u2u_pkg::core_state_t st
);
  import u2u_pkg::*;

  logic [ACC_W-1:0]  code_accum_r,   code_accum_nxt;
  logic [LEFT_W-1:0] bytes_left_r,   bytes_left_nxt;
  logic [LEN_W-1:0]  seq_length_r,   seq_length_nxt;
  logic              name_aborted_r, name_aborted_nxt;
  logic [ACC_W-1:0]  acc_shift;
  logic [LEFT_W-1:0] left_dec;
  logic [7:0]        b;
  logic              last;

  assign b         = item.byte_in;
  assign last      = item.last_of_name;
  assign acc_shift = {code_accum_r[ACC_W-7:0], b[5:0]};
  assign left_dec  = bytes_left_r - LEFT_W'(1);

  always_comb begin
    code_accum_nxt   = code_accum_r;
    bytes_left_nxt   = bytes_left_r;
    seq_length_nxt   = seq_length_r;
    name_aborted_nxt = name_aborted_r;
    res_valid        = 1'b0;
    res.code_unit    = '0;
    res.status       = ST_OK;
    res.end_of_name  = last;

    if (name_aborted_r) begin
      // Drop bytes until the end of the failed name.
      if (last) begin
        name_aborted_nxt = 1'b0;
        code_accum_nxt   = '0;
        bytes_left_nxt   = '0;
        seq_length_nxt   = '0;
      end
    end else if (bytes_left_r == '0) begin
      if (b[7] == 1'b0) begin
        code_accum_nxt = '0;
        seq_length_nxt = '0;
        res_valid      = 1'b1;
        res.code_unit  = {8'h00, b};
      end else if ((b & 8'hE0) == 8'hC0) begin
        code_accum_nxt = {16'h0, b[4:0]};
        seq_length_nxt = LEN_W'(2);
        bytes_left_nxt = LEFT_W'(1);
      end else if ((b & 8'hF0) == 8'hE0) begin
        code_accum_nxt = {17'h0, b[3:0]};
        seq_length_nxt = LEN_W'(3);
        bytes_left_nxt = LEFT_W'(2);
      end else if ((b & 8'hF8) == 8'hF0) begin
        code_accum_nxt = {18'h0, b[2:0]};
        seq_length_nxt = LEN_W'(4);
        bytes_left_nxt = LEFT_W'(3);
      end else begin
        res_valid  = 1'b1;
        res.status = ST_BAD_LEAD;
      end
      // A lead byte that also ends the name is a truncated sequence.
      if (b[7] == 1'b1 && (b & 8'hC0) == 8'hC0 && (b & 8'hF8) != 8'hF8 && last) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNC;
      end
      if (res_valid && res.status != ST_OK) begin
        code_accum_nxt   = '0;
        bytes_left_nxt   = '0;
        seq_length_nxt   = '0;
        name_aborted_nxt = ~last;
      end
    end else begin
      code_accum_nxt = acc_shift;
      bytes_left_nxt = left_dec;
      if (left_dec != '0) begin
        if (last) begin
          res_valid  = 1'b1;
          res.status = ST_TRUNC;
        end
      end else begin
        res_valid = 1'b1;
        if (acc_shift <= BMP_TOP) begin
          res.code_unit = acc_shift[UNIT_W-1:0];
        end else if (acc_shift <= UNICODE_TOP) begin
          res.status = ST_ASTRAL;
        end else begin
          res.status = ST_TOO_BIG;
        end
      end
      if (res_valid) begin
        code_accum_nxt = '0;
        bytes_left_nxt = '0;
        seq_length_nxt = '0;
        if (res.status != ST_OK) begin
          name_aborted_nxt = ~last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_accum_r   <= '0;
      bytes_left_r   <= '0;
      seq_length_r   <= '0;
      name_aborted_r <= 1'b0;
    end else if (step) begin
      code_accum_r   <= code_accum_nxt;
      bytes_left_r   <= bytes_left_nxt;
      seq_length_r   <= seq_length_nxt;
      name_aborted_r <= name_aborted_nxt;
    end
  end

  assign st.bytes_left   = bytes_left_r;
  assign st.seq_length   = seq_length_r;
  assign st.name_aborted = name_aborted_r;

endmodule

// ===== rtl/u2u_out_reg.sv =====
// Result register: holds one result request until the receiver takes it.
module u2u_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  u2u_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_valid,
  output u2u_pkg::result_t out_res,
  output logic             can_load
);
  import u2u_pkg::*;

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;

  assign can_load = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/utf8_to_utf16_stream_decoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 stream decoder.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one UTF-8 byte per request,
//   with in_last_of_name marking the final byte of a name.
//   Result channel (out_valid / out_stall) carries one UTF-16 code unit or
//   one error status per result request; out_end_of_name is set when the
//   result came from the name's last byte. Error results carry code unit 0.
//   Lead bytes and inner continuation bytes give no result unless they end
//   the name; then they give a truncation status.
// Path: a byte that gives a result waits in the input register, is decoded
//   and loaded into the result register, which shows it until taken.
// Throughput: one byte per cycle unless the result side stalls, set by the
//   single decode step between the input register and the result register.
// Reset (rst_n low, synchronous): both channels empty, sequence state
//   cleared, no name being dropped.
// Stall: while the result register holds a request and out_stall is high,
//   a byte that would give a result waits in the input register and
//   in_stall rises; bytes that give no result still pass.
module utf8_to_utf16_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_of_name,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic [2:0]  out_status,
  output logic        out_end_of_name
);
  import u2u_pkg::*;

  in_item_t    in_item;
  in_item_t    s1_item;
  logic        s1_valid;
  logic        step_ok;
  logic        step;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  core_state_t st;
  logic        can_load;

  assign in_item.byte_in      = in_byte_in;
  assign in_item.last_of_name = in_last_of_name;

  // Step the decoder unless its result would land on a stalled full register.
  assign step_ok = can_load | ~res_valid;
  assign step    = s1_valid & step_ok;

  u2u_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .step_ok  (step_ok),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  u2u_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res),
    .st        (st)
  );

  u2u_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step & res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign out_code_unit   = out_res.code_unit;
  assign out_status      = out_res.status;
  assign out_end_of_name = out_res.end_of_name;

  // Idle sequence and zero continuation count go together.
  a_len_left: assert property (@(posedge clk) disable iff (!rst_n)
    (st.seq_length == '0) == (st.bytes_left == '0))
    else $error("sequence length and bytes left disagree");

  // While a name is dropped no sequence is in progress.
  a_abort_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st.name_aborted |-> (st.bytes_left == '0))
    else $error("sequence open while dropping a name");

  // Error results carry a zero code unit.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_code_unit == '0))
    else $error("error result with nonzero code unit");

  // A result never overwrites one the receiver has not taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !(step && res_valid))
    else $error("result register overrun");

endmodule

// ===== dv/utf8_to_utf16_stream_decoder_unit_tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder top level.
module utf8_to_utf16_stream_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2u_pkg::*;

  localparam int RANDOM_BYTES = 1900;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_byte_in;
  logic              in_last_of_name;
  logic              out_valid;
  logic              out_stall;
  logic [UNIT_W-1:0] out_code_unit;
  logic [ST_W-1:0]   out_status;
  logic              out_end_of_name;

  utf8_to_utf16_stream_decoder_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .in_last_of_name (in_last_of_name),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_status      (out_status),
    .out_end_of_name (out_end_of_name)
  );

  // 10 ns clock: low half, then high half.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder shadow state, advanced once per accepted input request.
  logic [ACC_W-1:0]  dec_acc;
  logic [LEFT_W-1:0] dec_left;
  logic [LEN_W-1:0]  dec_len;
  logic              dec_abort;

  // Code units and error statuses still owed by the block, oldest first.
  result_t units_due[$];

  int n_errors;
  int n_taken;
  int n_dropped;
  int n_results;
  int st_seen[5];

  // Idle-pattern state: a quiet side goes back to back, a busy one draws gaps.
  bit in_quiet;
  bit out_quiet;

  // One directed row: byte, last flag, and an optional typed-in expectation.
  typedef struct packed {
    logic [7:0]        b;
    logic              l;
    bit                pin;
    bit                has;
    logic [UNIT_W-1:0] unit;
    logic [ST_W-1:0]   st;
  } dir_row_t;

  localparam int N_DIR = 25;

  // Rows with pin clear take their expectation from decode_byte.
  dir_row_t dir_rows [0:N_DIR-1] = '{
    // ASCII extremes, alone and closing a name
    '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, ST_OK},
    '{8'h7F, 1'b1, 1'b1, 1'b1, 16'h007F, ST_OK},
    // overlong two-byte form passes unchecked
    '{8'hC0, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    // three-byte euro sign closing the name
    '{8'hE2, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'h82, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'hAC, 1'b1, 1'b0, 1'b0, 16'h0000, ST_OK},
    // top of the basic plane
    '{8'hEF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'hBF, 1'b0, 1'b1, 1'b1, 16'hFFFF, ST_OK},
    // astral code point mid-name, then the rest of the name is dropped
    '{8'hF0, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'h9F, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'h98, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'h80, 1'b0, 1'b1, 1'b1, 16'h0000, ST_ASTRAL},
    '{8'h42, 1'b1, 1'b1, 1'b0, 16'h0000, ST_OK},
    // largest four-byte value, above the Unicode top, on the last byte
    '{8'hF7, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'hBF, 1'b1, 1'b1, 1'b1, 16'h0000, ST_TOO_BIG},
    // invalid leads: a stray continuation, then 0xF8 mid-name
    '{8'h80, 1'b1, 1'b1, 1'b1, 16'h0000, ST_BAD_LEAD},
    '{8'hF8, 1'b0, 1'b1, 1'b1, 16'h0000, ST_BAD_LEAD},
    '{8'h41, 1'b1, 1'b1, 1'b0, 16'h0000, ST_OK},
    // truncation after a continuation byte, and right at the lead
    '{8'hE1, 1'b0, 1'b0, 1'b0, 16'h0000, ST_OK},
    '{8'h80, 1'b1, 1'b1, 1'b1, 16'h0000, ST_TRUNC},
    '{8'hC3, 1'b1, 1'b1, 1'b1, 16'h0000, ST_TRUNC}
  };

  task automatic clear_sequence();
    dec_acc  = '0;
    dec_left = '0;
    dec_len  = '0;
  endtask

  // Advance the shadow decoder by one byte; has tells whether a result is due.
  task automatic decode_byte(input logic [7:0] b, input logic l,
                             output bit has, output result_t r);
    logic [ACC_W-1:0] cp;
    bit               failed;
    logic [ST_W-1:0]  st;
    has           = 1'b0;
    failed        = 1'b0;
    st            = ST_OK;
    r.code_unit   = '0;
    r.status      = ST_OK;
    r.end_of_name = l;
    if (dec_abort) begin
      // Drop everything up to and including the name's last byte.
      if (l) begin
        dec_abort = 1'b0;
        clear_sequence();
      end
    end else if (dec_left == '0) begin
      if (b[7] == 1'b0) begin
        clear_sequence();
        has         = 1'b1;
        r.code_unit = {8'h00, b};
      end else if (b[7:5] == 3'b110) begin
        dec_acc = {16'h0000, b[4:0]};
        dec_len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        dec_acc = {17'h00000, b[3:0]};
        dec_len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        dec_acc = {18'h00000, b[2:0]};
        dec_len = 3'd4;
      end else begin
        failed = 1'b1;
        st     = ST_BAD_LEAD;
      end
      if (!failed && dec_len != '0) begin
        dec_left = dec_len[LEFT_W-1:0] - 2'd1;
        if (l) begin
          failed = 1'b1;
          st     = ST_TRUNC;
        end
      end
    end else begin
      // Continuation: take the low six bits, nothing else is checked.
      dec_acc  = {dec_acc[ACC_W-7:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left != '0) begin
        if (l) begin
          failed = 1'b1;
          st     = ST_TRUNC;
        end
      end else begin
        cp = dec_acc;
        clear_sequence();
        if (cp <= BMP_TOP) begin
          has         = 1'b1;
          r.code_unit = cp[UNIT_W-1:0];
        end else if (cp <= UNICODE_TOP) begin
          failed = 1'b1;
          st     = ST_ASTRAL;
        end else begin
          failed = 1'b1;
          st     = ST_TOO_BIG;
        end
      end
    end
    if (failed) begin
      // An error on the last byte leaves the next name clean.
      clear_sequence();
      dec_abort   = !l;
      has         = 1'b1;
      r.code_unit = '0;
      r.status    = st;
    end
  endtask

  // Pick the wait before the next request; now and then flip between quiet and busy.
  function automatic int draw_wait(ref bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Offer one byte, hold it until accepted, then book the expected result.
  task automatic send_byte(input logic [7:0] b, input logic l, input bit pin,
                           input bit pin_has, input result_t pin_r);
    int      gap;
    bit      has;
    result_t r;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte_in      <= b;
    in_last_of_name <= l;
    do @(posedge clk); while (in_stall);
    if (dec_abort) n_dropped++;
    else n_taken++;
    decode_byte(b, l, has, r);
    if (pin) begin
      has = pin_has;
      r   = pin_r;
    end
    if (has) units_due.push_back(r);
  endtask

  function automatic logic [7:0] cont_byte();
    // Mostly well-formed 10xxxxxx, sometimes any byte at all.
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Build one name of random characters, sometimes cut short, and send it.
  task automatic send_random_name();
    logic [7:0] name_q[$];
    int         n_chars;
    int         kind;
    int         keep;
    result_t    none;
    none    = '0;
    n_chars = $urandom_range(1, 8);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        name_q.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 60) begin
        name_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        name_q.push_back(cont_byte());
      end else if (kind < 82) begin
        name_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        repeat (2) name_q.push_back(cont_byte());
      end else if (kind < 92) begin
        name_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        repeat (3) name_q.push_back(cont_byte());
      end else begin
        name_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // Cut some names anywhere so the last flag lands mid-sequence.
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, name_q.size());
      while (name_q.size() > keep) void'(name_q.pop_back());
    end
    foreach (name_q[i])
      send_byte(name_q[i], i == name_q.size() - 1, 1'b0, 1'b0, none);
  endtask

  // Result side: stall a random while before each result, then take it.
  initial begin
    int n;
    out_stall = 1'b0;
    out_quiet = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = draw_wait(out_quiet);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_status < 5) st_seen[out_status]++;
      if (units_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result exp none got unit %h status %0d end %0b",
                 $time, out_code_unit, out_status, out_end_of_name);
      end else begin
        want = units_due.pop_front();
        if (out_code_unit !== want.code_unit) begin
          n_errors++;
          $display("%0t: code_unit mismatch exp %h got %h",
                   $time, want.code_unit, out_code_unit);
        end
        if (out_status !== want.status) begin
          n_errors++;
          $display("%0t: status mismatch exp %0d got %0d",
                   $time, want.status, out_status);
        end
        if (out_end_of_name !== want.end_of_name) begin
          n_errors++;
          $display("%0t: end_of_name mismatch exp %0b got %0b",
                   $time, want.end_of_name, out_end_of_name);
        end
      end
    end
  end

  // Main sequence: reset, directed rows, random names, drain, verdict.
  initial begin
    result_t pinned;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_byte_in      = 8'h00;
    in_last_of_name = 1'b0;
    in_quiet        = 1'b0;
    n_errors        = 0;
    n_taken         = 0;
    n_dropped       = 0;
    n_results       = 0;
    foreach (st_seen[i]) st_seen[i] = 0;
    dec_abort = 1'b0;
    clear_sequence();

    // Hold reset, then release it on an edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: typed-in rows override the shadow decoder's answer.
    for (int i = 0; i < N_DIR; i++) begin
      pinned.code_unit   = dir_rows[i].unit;
      pinned.status      = dir_rows[i].st;
      pinned.end_of_name = dir_rows[i].l;
      send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].pin, dir_rows[i].has, pinned);
    end

    // Random part: mostly well-formed names, every accepted byte counted.
    while (n_taken + n_dropped < N_DIR + RANDOM_BYTES) send_random_name();

    in_valid <= 1'b0;

    // Drain what is still owed, then allow the pipeline to settle.
    while (units_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d decoded bytes, %0d dropped after errors, %0d results checked.",
             n_taken, n_dropped, n_results);
    $display("Status mix: ok %0d, astral %0d, too big %0d, bad lead %0d, truncated %0d.",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still owed", units_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
